// ----- rtl/core/haci_pkg.sv -----
// Shared types, constants and hash function for the arena cache index.
`timescale 1ns / 1ps
package haci_pkg;

  localparam int SLOT_BITS   = 9;
  localparam int SLOT_COUNT  = 1 << SLOT_BITS;
  localparam int HASH_BITS   = 9;
  localparam int TOTAL_BITS  = SLOT_BITS + 1;
  localparam int FLUSH_LIMIT = SLOT_COUNT * 3 / 4;
  localparam int EPOCH_BITS  = 8;

  localparam logic [31:0] HASH_MULT   = 32'd2654435769;
  localparam logic [15:0] ARENA_RESET = 16'd32768;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_NEW    = 3'd2,
    ST_REJECT = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [15:0] size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] offset;
    logic        flushed;
  } rsp_t;

  typedef struct packed {
    logic    accept;
    logic    probe_next;
    logic    probe_home;
    logic    insert;
    logic    sweep_step;
    logic    load_out;
    status_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_short;
    logic req_insert;
    logic slot_hit;
    logic slot_empty;
    logic probe_last;
    logic flush_need;
    logic epoch_last;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [SLOT_BITS-1:0] home_slot(input logic [31:0] prod);
    logic [HASH_BITS-1:0] h;
    h = prod[31 -: HASH_BITS];
    return SLOT_BITS'(h % SLOT_COUNT);
  endfunction

endpackage

// ----- rtl/core/hashed_arena_cache_index.sv -----
// Top level of the hashed arena cache index.
//
//   channel  signals                        payload
//   req      req_valid / req_ready          req   (req_type, key, size)
//   rsp      rsp_valid / rsp_ready          rsp   (status, offset, flushed)
//   cfg      cfg_valid / cfg_ready          cfg_data (arena_bytes)
//
// A lookup or insert steps through accept, slot read and check when the home slot decides it,
// plus a further slot read and check for each further slot probed; each probe waits on the registered slot read.
// Key zero lookups and rejected inserts skip the slot read and go from accept to the reply.
// After reset a clearing pass over all SLOT_COUNT slots runs before the first request is taken.
// A flush is an epoch bump; once the epoch counter wraps, that flush adds a clearing pass and
// a home slot reread. A stalled result holds the controller.
`timescale 1ns / 1ps
module hashed_arena_cache_index (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  haci_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output haci_pkg::rsp_t  rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data
);
  import haci_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  haci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  haci_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending transaction");

  a_insert_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> cmd.load_out)
    else $error("slot written without a result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while one is in flight");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_step |-> !req_ready && !cmd.insert)
    else $error("request or insert during clearing pass");

endmodule

// ----- rtl/core/haci_dp.sv -----
// Datapath: request and result registers, slot memory, probe and arena counters.
`timescale 1ns / 1ps
module haci_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  haci_pkg::req_t        req,
  input  logic                  rsp_ready,
  output logic                  rsp_valid,
  output haci_pkg::rsp_t        rsp,
  input  logic                  cfg_valid,
  input  logic [15:0]           cfg_data,
  input  haci_pkg::ctrl_cmd_t   cmd,
  output haci_pkg::dp_stat_t    stat
);
  import haci_pkg::*;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [31:0]           key;
    logic [15:0]           offset;
  } slot_word_t;

  slot_word_t mem [SLOT_COUNT];
  slot_word_t rd_word;
  slot_word_t wr_word;
  logic [SLOT_BITS-1:0] wr_addr;
  logic                 wr_en;

  req_t                  req_q;
  logic [SLOT_BITS-1:0]  home_q;
  logic [SLOT_BITS-1:0]  probe_addr;
  logic [SLOT_BITS-1:0]  probe_cnt;
  logic [SLOT_BITS-1:0]  sweep_addr;
  logic [EPOCH_BITS-1:0] epoch;
  logic [15:0]           wp;
  logic [TOTAL_BITS-1:0] total;
  logic [15:0]           arena;
  logic [31:0]           hash_prod;
  logic [16:0]           wp_end;

  assign hash_prod = req.key * HASH_MULT;
  assign wp_end    = {1'b0, wp} + {1'b0, req_q.size};

  assign stat.in_short   = req.req_type ?
                           (req.key == 32'd0 || req.size == 16'd0 || req.size > arena) :
                           (req.key == 32'd0);
  assign stat.req_insert = req_q.req_type;
  assign stat.slot_empty = rd_word.tag != epoch;
  assign stat.slot_hit   = rd_word.tag == epoch && rd_word.key == req_q.key;
  assign stat.probe_last = &probe_cnt;
  assign stat.flush_need = wp_end > {1'b0, arena} || total >= TOTAL_BITS'(FLUSH_LIMIT);
  assign stat.epoch_last = &epoch;
  assign stat.sweep_last = &sweep_addr;
  assign stat.out_free   = !rsp_valid || rsp_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = probe_addr;
    wr_word = '{tag: epoch, key: req_q.key, offset: wp};
    if (cmd.sweep_step) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr;
      wr_word = '{tag: '0, key: req_q.key, offset: wp};
    end else if (cmd.insert) begin
      wr_en = 1'b1;
      if (stat.flush_need) begin
        wr_addr = home_q;
        wr_word = '{tag: epoch + 1'b1, key: req_q.key, offset: 16'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word <= mem[probe_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q      <= req;
      home_q     <= home_slot(hash_prod);
      probe_addr <= home_slot(hash_prod);
      probe_cnt  <= '0;
    end else if (cmd.probe_home) begin
      probe_addr <= home_q;
      probe_cnt  <= '0;
    end else if (cmd.probe_next) begin
      probe_addr <= probe_addr + 1'b1;
      probe_cnt  <= probe_cnt + 1'b1;
    end
    if (cmd.load_out) begin
      rsp.status  <= cmd.code;
      rsp.flushed <= cmd.insert && stat.flush_need;
      if (cmd.code == ST_HIT) begin
        rsp.offset <= rd_word.offset;
      end else if (cmd.insert && !stat.flush_need) begin
        rsp.offset <= wp;
      end else begin
        rsp.offset <= 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch      <= EPOCH_BITS'(1);
      wp         <= '0;
      total      <= '0;
      arena      <= ARENA_RESET;
      rsp_valid  <= 1'b0;
      sweep_addr <= '0;
    end else begin
      if (cfg_valid) begin
        arena <= cfg_data;
      end
      if (cmd.sweep_step) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (stat.sweep_last) begin
          epoch <= EPOCH_BITS'(1);
        end
      end
      if (cmd.insert) begin
        if (stat.flush_need) begin
          epoch <= epoch + 1'b1;
          wp    <= req_q.size;
          total <= TOTAL_BITS'(1);
        end else begin
          wp    <= wp_end[15:0];
          total <= total + 1'b1;
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/haci_ctrl.sv -----
// Controller: sequences accept, probe, insert, flush sweep and result load.
`timescale 1ns / 1ps
module haci_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  haci_pkg::dp_stat_t   stat,
  output haci_pkg::ctrl_cmd_t  cmd
);
  import haci_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_REPLY
  } state_t;

  state_t state, state_next;
  logic   pending, pending_next;
  logic   flushable;

  assign flushable = stat.req_insert && stat.flush_need;

  always_comb begin
    state_next   = state;
    pending_next = pending;
    req_ready    = 1'b0;
    cmd          = '{accept: 1'b0, probe_next: 1'b0, probe_home: 1'b0, insert: 1'b0,
                     sweep_step: 1'b0, load_out: 1'b0, code: ST_MISS};
    case (state)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next   = pending ? S_READ : S_IDLE;
          pending_next = 1'b0;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.in_short ? S_REPLY : S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.out_free) begin
          if (stat.slot_hit) begin
            cmd.load_out = 1'b1;
            cmd.code     = ST_HIT;
            state_next   = S_IDLE;
          end else if (stat.slot_empty || stat.probe_last) begin
            if (flushable && stat.epoch_last) begin
              cmd.probe_home = 1'b1;
              pending_next   = 1'b1;
              state_next     = S_SWEEP;
            end else if (stat.req_insert && (stat.slot_empty || flushable)) begin
              cmd.insert   = 1'b1;
              cmd.load_out = 1'b1;
              cmd.code     = ST_NEW;
              state_next   = S_IDLE;
            end else begin
              cmd.load_out = 1'b1;
              cmd.code     = stat.req_insert ? ST_FULL : ST_MISS;
              state_next   = S_IDLE;
            end
          end else begin
            cmd.probe_next = 1'b1;
            state_next     = S_READ;
          end
        end
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.code     = stat.req_insert ? ST_REJECT : ST_MISS;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

endmodule

// ----- bench/hashed_arena_cache_index_tb.sv -----
// Self-checking bench for the arena cache index: hashed lookup/insert with flushes.
`timescale 1ns / 1ps
module hashed_arena_cache_index_tb;
  import haci_pkg::*;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;
  localparam int QUIET_LIMIT = 20000;
  localparam int POOL_DEPTH = 64;

  typedef struct {
    req_t q;
    rsp_t a;
  } outcome_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  // predicted index contents
  logic [31:0] tbl_key [SLOT_COUNT];
  bit          tbl_used [SLOT_COUNT];
  logic [15:0] tbl_off [SLOT_COUNT];
  logic [15:0] bump_ptr = '0;
  int unsigned live_entries = 0;
  logic [15:0] arena_cap = ARENA_RESET;

  req_t        pending_reqs [$];
  outcome_t    due_outcomes [$];
  logic [31:0] key_pool [$];

  int issued = 0;
  int checked = 0;
  int errors = 0;
  int cfg_writes = 0;
  int n_hit = 0, n_miss = 0, n_new = 0, n_reject = 0, n_flush = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit [15:0] tick = '0;

  hashed_arena_cache_index i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int hash_home(input logic [31:0] k);
    logic [31:0] prod;
    prod = k * HASH_MULT;
    return int'(prod >> (32 - HASH_BITS)) % SLOT_COUNT;
  endfunction

  function automatic int probe_slot(input logic [31:0] k);
    int h;
    int s;
    h = hash_home(k);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      s = (h + i) % SLOT_COUNT;
      if (!tbl_used[s] || tbl_key[s] == k) return s;
    end
    return SLOT_COUNT;
  endfunction

  function automatic rsp_t cache_outcome(input req_t r);
    rsp_t o;
    int s;
    logic [16:0] reach;
    o = '0;
    if (r.req_type == OP_LOOKUP) begin
      o.status = ST_MISS;
      if (r.key != 0) begin
        s = probe_slot(r.key);
        if (s < SLOT_COUNT && tbl_used[s] && tbl_key[s] == r.key) begin
          o.status = ST_HIT;
          o.offset = tbl_off[s];
        end
      end
    end else if (r.key == 0 || r.size == 0 || r.size > arena_cap) begin
      o.status = ST_REJECT;
    end else begin
      s = probe_slot(r.key);
      if (s < SLOT_COUNT && tbl_used[s] && tbl_key[s] == r.key) begin
        o.status = ST_HIT;
        o.offset = tbl_off[s];
      end else begin
        reach = {1'b0, bump_ptr} + r.size;
        if (reach > arena_cap || live_entries >= FLUSH_LIMIT) begin
          foreach (tbl_used[j]) tbl_used[j] = 1'b0;
          bump_ptr = '0;
          live_entries = 0;
          o.flushed = 1'b1;
          s = probe_slot(r.key);
        end
        if (s >= SLOT_COUNT) begin
          o.status = ST_FULL;
        end else begin
          tbl_used[s] = 1'b1;
          tbl_key[s] = r.key;
          tbl_off[s] = bump_ptr;
          o.offset = bump_ptr;
          bump_ptr = bump_ptr + r.size;
          live_entries++;
          o.status = ST_NEW;
        end
      end
    end
    return o;
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic queue_req(input logic op, input logic [31:0] k, input logic [15:0] sz);
    req_t r;
    r.req_type = op;
    r.key = k;
    r.size = sz;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] key_at_home(input int target);
    logic [31:0] k;
    do k = $urandom; while (k == 0 || hash_home(k) != target);
    return k;
  endfunction

  task automatic queue_directed();
    logic [31:0] ka, kb, kc, kd, ke, kf;
    ka = key_at_home(SLOT_COUNT - 1);
    kb = key_at_home(SLOT_COUNT - 1);
    kc = key_at_home(SLOT_COUNT - 1);
    kd = key_at_home(SLOT_COUNT - 1);
    ke = $urandom | 32'h1;
    kf = $urandom | 32'h2;
    queue_req(OP_LOOKUP, '0, 16'hFFFF);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    queue_req(OP_INSERT, '0, 16'd5);
    queue_req(OP_INSERT, 32'd1, '0);
    queue_req(OP_INSERT, 32'd2, ARENA_RESET + 16'd1);
    queue_req(OP_INSERT, 32'hFFFF_FFFF, 16'd100);
    queue_req(OP_INSERT, ka, 16'd1);
    queue_req(OP_INSERT, kb, 16'd2);
    queue_req(OP_INSERT, kc, 16'd3);
    queue_req(OP_LOOKUP, kc, 16'h5555);
    queue_req(OP_INSERT, kb, 16'd7);
    queue_req(OP_LOOKUP, kd, 16'hAAAA);
    queue_req(OP_INSERT, ke, ARENA_RESET);
    queue_req(OP_LOOKUP, ka, '0);
    queue_req(OP_INSERT, kf, 16'd1);
    queue_req(OP_LOOKUP, ke, '0);
    queue_req(OP_INSERT, 32'h8000_0000, 16'hFFFF);
    queue_req(OP_LOOKUP, 32'h8000_0000, '0);
    queue_req(OP_INSERT, 32'h1234_5678, ARENA_RESET - 16'd1);
    queue_req(OP_LOOKUP, kf, '0);
    queue_req(OP_INSERT, kf, '0);
    queue_req(OP_LOOKUP, 32'h1234_5678, 16'hFFFF);
  endtask

  // keep going until both counts are reached; fresh inserts drive the table load
  task automatic queue_phase(input int n_items, input int n_fresh, input int insert_pct,
                             input int reuse_pct, input int size_hi, input int wild_pct);
    req_t r;
    int made;
    int fresh_n;
    int pick;
    bit fresh;
    made = 0;
    fresh_n = 0;
    while (made < n_items || fresh_n < n_fresh) begin
      r.req_type = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
      pick = $urandom_range(0, 99);
      fresh = 1'b0;
      if (pick < 3) begin
        r.key = '0;
      end else if (pick < 3 + reuse_pct && key_pool.size() > 0) begin
        r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        r.key = $urandom;
        fresh = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) r.size = '0;
      else if (pick < 2 + wild_pct || r.req_type == OP_LOOKUP) r.size = 16'($urandom);
      else r.size = 16'($urandom_range(1, size_hi));
      if (r.req_type == OP_INSERT && fresh && r.key != 0 && r.size != 0) begin
        fresh_n++;
        key_pool.push_back(r.key);
        if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
      pending_reqs.push_back(r);
      made++;
    end
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || issued != checked) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_arena(input logic [15:0] bytes);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= bytes;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    arena_cap = bytes;
    cfg_writes++;
  endtask

  // request side: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_valid && req_ready) due_outcomes.push_back('{req, cache_outcome(req)});
      if (!req_valid || req_ready) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_valid <= 1'b0;
        end else begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          issued++;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // response side: stall pattern that rotates with bits 9:8 of the tick counter, plus one long hold
  always @(posedge clk) begin
    outcome_t exp;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_outcomes.size() == 0) begin
          flag_mismatch($sformatf("unexpected response status %0d offset %0d",
                                  rsp.status, rsp.offset));
        end else begin
          exp = due_outcomes.pop_front();
          checked++;
          if (rsp.status !== exp.a.status)
            flag_mismatch($sformatf("key %h size %0d op %0d: status %0d, want %0d",
                                    exp.q.key, exp.q.size, exp.q.req_type,
                                    rsp.status, exp.a.status));
          if (rsp.offset !== exp.a.offset)
            flag_mismatch($sformatf("key %h size %0d op %0d: offset %0d, want %0d",
                                    exp.q.key, exp.q.size, exp.q.req_type,
                                    rsp.offset, exp.a.offset));
          if (rsp.flushed !== exp.a.flushed)
            flag_mismatch($sformatf("key %h size %0d op %0d: flushed %0d, want %0d",
                                    exp.q.key, exp.q.size, exp.q.req_type,
                                    rsp.flushed, exp.a.flushed));
          case (exp.a.status)
            ST_HIT:    n_hit++;
            ST_MISS:   n_miss++;
            ST_NEW:    n_new++;
            ST_REJECT: n_reject++;
            default: ;
          endcase
          if (exp.a.flushed) n_flush++;
          if (checked == 90) hold_left = 200;
        end
      end
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (tick[9:8])
          2'd0: rsp_ready <= 1'b1;
          2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
          2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ready <= tick[2];
        endcase
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    foreach (tbl_used[j]) tbl_used[j] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    settle();
    write_arena(16'hFFFF);
    queue_phase(0, 385, 100, 2, 16, 0);
    settle();
    write_arena(16'd1);
    queue_phase(12, 0, 70, 30, 1, 10);
    settle();
    write_arena(16'd300);
    queue_phase(12, 0, 70, 30, 300, 5);
    settle();
    write_arena(16'd40000);
    queue_phase(12, 0, 85, 20, 4000, 5);
    settle();
    write_arena(16'd1000);
    queue_phase(12, 0, 40, 70, 200, 5);
    settle();
    repeat (20) @(posedge clk);
    $display("run: %0d transactions over %0d arena sizes, %0d flushes", checked,
             cfg_writes + 1, n_flush);
    $display("outcomes: %0d hit, %0d miss, %0d new, %0d rejected", n_hit, n_miss, n_new,
             n_reject);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
